/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/wdoq_pkg.sv */
package wdoq_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int CAP_W     = 20;
  localparam int TAG_W     = 16;
  localparam int WT_W      = 16;
  localparam int ITEMS_W   = 7;
  localparam int IN_W      = 40;
  localparam int OUT_W     = 88;
  localparam int WORD_W    = TAG_W + WT_W;

  localparam logic [CAP_W-1:0] CAP_RESET = 20'd1024;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_TRIM = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TAKE
  } state_t;

  typedef struct packed {
    logic [CAP_W-1:0]   q_events;
    logic [ITEMS_W-1:0] q_items;
    logic [CAP_W-1:0]   ev_events;
    logic [ITEMS_W-1:0] ev_items;
    logic [WT_W-1:0]    weight;
    logic [TAG_W-1:0]   tag;
    logic               ok;
  } result_t;

endpackage

/* rtl/weighted_drop_oldest_queue_unit.sv */
// Weighted drop-oldest queue: a ring of tagged items in one slot memory. A push is
// stored only if the total weight held then stays at or below the capacity register.
// Each input word is one command (push, pop or trim) and yields exactly one result
// word. A push that fits, a refused pop, a trim with nothing to drop and the unused
// code give their result from ST_CHECK; a pop that delivers gives it from ST_TAKE, once
// the head entry is read from the slot memory. Every item dropped from the head by a
// push or a trim is read in ST_CHECK and retired in ST_TAKE, since the memory has one
// read port. The next word is taken while a finished result still waits in the output
// register; a result that cannot be loaded holds the engine. No clearing pass follows
// reset: only occupied slots are ever read.
module weighted_drop_oldest_queue_unit import wdoq_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata,
  input  logic             s_tvalid,
  output logic             s_tready,
  // op[1:0], tag[17:2], weight[33:18], pop_allowed[34], zero fill
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // ok[0], out_tag[16:1], out_weight[32:17], evicted_items[39:33],
  // evicted_events[59:40], queued_items[66:60], queued_events[86:67], zero fill
  output logic [OUT_W-1:0] m_tdata
);

  localparam int AW = $clog2(SLOTS);

  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [WORD_W-1:0] mem_rdata;
  logic              res_valid;
  logic              res_ready;
  result_t           res;

  wdoq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  wdoq_ctrl #(
    .SLOTS (SLOTS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  wdoq_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

/* rtl/wdoq_ram.sv */
module wdoq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* rtl/wdoq_ctrl.sv */
module wdoq_ctrl import wdoq_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [IN_W-1:0]          in_data,
  output logic                     mem_we,
  output logic [$clog2(SLOTS)-1:0] mem_waddr,
  output logic [WORD_W-1:0]        mem_wdata,
  output logic                     mem_re,
  output logic [$clog2(SLOTS)-1:0] mem_raddr,
  input  logic [WORD_W-1:0]        mem_rdata,
  output logic                     res_valid,
  input  logic                     res_ready,
  output result_t                  res
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(SLOTS - 1);
  localparam logic [CW-1:0] FULL_CNT  = CW'(SLOTS);

  state_t           state, state_next;
  op_t              op;
  logic [TAG_W-1:0] tag;
  logic [WT_W-1:0]  weight;
  logic             allowed;
  logic [CAP_W-1:0] cap;
  logic [AW-1:0]    head, head_next;
  logic [AW-1:0]    tail, tail_next;
  logic [CW-1:0]    count, count_next;
  logic [CAP_W-1:0] total, total_next;
  logic [CW-1:0]    ev_items, ev_items_next;
  logic [CAP_W-1:0] ev_events, ev_events_next;

  logic             r_ok;
  logic [TAG_W-1:0] r_tag;
  logic [WT_W-1:0]  r_wt;
  logic [CAP_W:0]   sum;
  logic             over, full, empty;
  logic [WT_W-1:0]  hw;

  assign in_ready  = (state == ST_IDLE);
  assign sum       = {1'b0, total} + {{(CAP_W + 1 - WT_W){1'b0}}, weight};
  assign over      = sum > {1'b0, cap};
  assign full      = (count == FULL_CNT);
  assign empty     = (count == '0);
  assign hw        = mem_rdata[WT_W-1:0];
  assign mem_waddr = tail;
  assign mem_wdata = {tag, weight};
  assign mem_raddr = head;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cap       <= CAP_RESET;
      head      <= '0;
      tail      <= '0;
      count     <= '0;
      total     <= '0;
      ev_items  <= '0;
      ev_events <= '0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      count     <= count_next;
      total     <= total_next;
      ev_items  <= ev_items_next;
      ev_events <= ev_events_next;
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op      <= op_t'(in_data[1:0]);
      tag     <= in_data[17:2];
      weight  <= in_data[33:18];
      allowed <= in_data[34];
    end
  end

  always_comb begin
    state_next     = state;
    head_next      = head;
    tail_next      = tail;
    count_next     = count;
    total_next     = total;
    ev_items_next  = ev_items;
    ev_events_next = ev_events;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    res_valid      = 1'b0;
    r_ok           = 1'b0;
    r_tag          = '0;
    r_wt           = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next     = ST_CHECK;
          ev_items_next  = '0;
          ev_events_next = '0;
        end
      end
      ST_CHECK: begin
        case (op)
          OP_PUSH: begin
            if (!empty && (over || full)) begin
              mem_re     = 1'b1;
              state_next = ST_TAKE;
            end else if (!over) begin
              res_valid  = 1'b1;
              r_ok       = 1'b1;
              mem_we     = 1'b1;
              tail_next  = (tail == LAST_SLOT) ? '0 : tail + 1'b1;
              count_next = count + 1'b1;
              total_next = sum[CAP_W-1:0];
              state_next = ST_IDLE;
            end else begin
              res_valid  = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_POP: begin
            if (!empty && allowed) begin
              mem_re     = 1'b1;
              state_next = ST_TAKE;
            end else begin
              res_valid  = 1'b1;
              state_next = ST_IDLE;
            end
          end
          OP_TRIM: begin
            if (!empty && (total > cap)) begin
              mem_re     = 1'b1;
              state_next = ST_TAKE;
            end else begin
              res_valid  = 1'b1;
              state_next = ST_IDLE;
            end
          end
          default: begin
            res_valid  = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_TAKE: begin
        head_next  = (head == LAST_SLOT) ? '0 : head + 1'b1;
        count_next = count - 1'b1;
        total_next = (total >= CAP_W'(hw)) ? total - CAP_W'(hw) : '0;
        if (op == OP_POP) begin
          res_valid  = 1'b1;
          r_ok       = 1'b1;
          r_tag      = mem_rdata[WORD_W-1:WT_W];
          r_wt       = hw;
          state_next = ST_IDLE;
        end else begin
          ev_items_next  = ev_items + 1'b1;
          ev_events_next = ev_events + CAP_W'(hw);
          state_next     = ST_CHECK;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    res.ok        = r_ok;
    res.tag       = r_tag;
    res.weight    = r_wt;
    res.ev_items  = ITEMS_W'(ev_items);
    res.ev_events = ev_events;
    res.q_items   = ITEMS_W'(count_next);
    res.q_events  = total_next;

    // hold everything until the output register has room
    if (res_valid && !res_ready) begin
      state_next = state;
      head_next  = head;
      tail_next  = tail;
      count_next = count;
      total_next = total;
      mem_we     = 1'b0;
    end
  end

endmodule

/* rtl/wdoq_out.sv */
module wdoq_out import wdoq_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  output logic             res_ready,
  input  result_t          res,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  result_t held;

  assign res_ready = !m_tvalid || m_tready;
  assign m_tdata   = {{(OUT_W - $bits(result_t)){1'b0}}, held};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      held <= res;
    end
  end

endmodule

/* rtl/wdoq_checker.sv */
`include "assert_macros.svh"

module wdoq_checker import wdoq_pkg::*; (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  `ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
    m_tvalid && $stable(m_tdata), "stalled word changed")
  `ASSERT_NEXT(a_one_in_flight, clk, rst, s_tvalid && s_tready,
    !s_tready, "second word taken before result")
  `ASSERT_SAME(a_no_payload_on_fail, clk, rst, m_tvalid && !m_tdata[0],
    m_tdata[32:1] == 32'd0, "tag or weight set without ok")
  `ASSERT_NEXT(a_result_latency, clk, rst, s_tvalid && s_tready && !m_tvalid,
    !m_tvalid, "result appeared too early")

endmodule

bind weighted_drop_oldest_queue_unit wdoq_checker u_chk (.*);

/* dv/weighted_drop_oldest_queue_unit_tb.sv */
`timescale 1ns / 100ps

module weighted_drop_oldest_queue_unit_tb;
  import wdoq_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CAP_MAX = (1 << CAP_W) - 1;

  typedef struct packed {
    logic            pop_allowed;
    logic [WT_W-1:0]  weight;
    logic [TAG_W-1:0] tag;
    logic [1:0]      op;
  } queue_cmd_t;

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  logic [CAP_W-1:0] cfg_wdata = '0;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  weighted_drop_oldest_queue_unit uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  queue_cmd_t cmd_backlog[$];
  result_t    expected_results[$];
  queue_cmd_t cmd_on_bus;
  int         words_sent = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  int err_count = 0;
  int words_in = 0;
  int words_out = 0;
  int items_dropped = 0;
  int pops_delivered = 0;
  int pushes_refused = 0;
  int cap_settings = 0;

  logic [TAG_W-1:0] slot_tag [SLOTS_DEF];
  logic [WT_W-1:0]  slot_wt  [SLOTS_DEF];
  int head_idx = 0;
  int tail_idx = 0;
  int held_items = 0;
  int held_events = 0;
  int cap_now = CAP_RESET;

  function automatic int take_oldest();
    int w;
    w = slot_wt[head_idx];
    head_idx = (head_idx + 1) % SLOTS_DEF;
    held_items--;
    held_events -= w;
    return w;
  endfunction

  function automatic result_t queue_step(input queue_cmd_t c);
    result_t r;
    int dropped_n;
    int dropped_w;
    r = '0;
    dropped_n = 0;
    dropped_w = 0;
    case (c.op)
      OP_PUSH: begin
        while (held_items > 0 &&
               (held_events + c.weight > cap_now || held_items >= SLOTS_DEF)) begin
          dropped_w += take_oldest();
          dropped_n++;
        end
        if (held_events + c.weight <= cap_now && held_items < SLOTS_DEF) begin
          slot_tag[tail_idx] = c.tag;
          slot_wt[tail_idx] = c.weight;
          tail_idx = (tail_idx + 1) % SLOTS_DEF;
          held_items++;
          held_events += c.weight;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (held_items > 0 && c.pop_allowed) begin
          r.ok = 1'b1;
          r.tag = slot_tag[head_idx];
          r.weight = WT_W'(take_oldest());
        end
      end
      OP_TRIM: begin
        while (held_items > 0 && held_events > cap_now) begin
          dropped_w += take_oldest();
          dropped_n++;
        end
      end
      default: begin
      end
    endcase
    r.ev_items = dropped_n[ITEMS_W-1:0];
    r.ev_events = dropped_w[CAP_W-1:0];
    r.q_items = held_items[ITEMS_W-1:0];
    r.q_events = held_events[CAP_W-1:0];
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    if (err_count <= 40)
      $display("ERROR at %0t ns, result %0d: %s", $time, words_out, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
  endtask

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
      m_tready <= 1'b0;
    end else begin
      if (words_in == words_sent) begin
        if (cmd_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd_on_bus = cmd_backlog[0];
          cmd_backlog.delete(0);
          words_sent++;
          s_tvalid <= 1'b1;
          s_tdata <= {{(IN_W - $bits(queue_cmd_t)){1'b0}}, cmd_on_bus};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
      m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : monitor_blk
    result_t got;
    result_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        want = queue_step(cmd_on_bus);
        expected_results.insert(expected_results.size(), want);
        words_in++;
        items_dropped += want.ev_items;
        if (cmd_on_bus.op == OP_POP && want.ok)
          pops_delivered++;
        if (cmd_on_bus.op == OP_PUSH && !want.ok)
          pushes_refused++;
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[$bits(result_t)-1:0];
        if (expected_results.size() == 0) begin
          report_mismatch("result word with nothing outstanding");
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          check_field("ok", got.ok, want.ok);
          check_field("out_tag", got.tag, want.tag);
          check_field("out_weight", got.weight, want.weight);
          check_field("evicted_items", got.ev_items, want.ev_items);
          check_field("evicted_events", got.ev_events, want.ev_events);
          check_field("queued_items", got.q_items, want.q_items);
          check_field("queued_events", got.q_events, want.q_events);
        end
        words_out++;
      end
    end
  end

  task automatic enqueue_cmd(input logic [1:0] op, input int tag, input int weight,
                             input logic allow);
    queue_cmd_t c;
    c.op = op;
    c.tag = tag[TAG_W-1:0];
    c.weight = weight[WT_W-1:0];
    c.pop_allowed = allow;
    cmd_backlog.insert(cmd_backlog.size(), c);
  endtask

  function automatic queue_cmd_t rand_cmd(input int push_pct, input int wmax);
    queue_cmd_t c;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < push_pct) begin
      c.op = OP_PUSH;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 60)
        c.op = OP_POP;
      else if (roll < 95)
        c.op = OP_TRIM;
      else
        c.op = OP_UNUSED;
    end
    c.tag = TAG_W'($urandom);
    case ($urandom_range(0, 15))
      0: c.weight = '0;
      1: c.weight = '1;
      default: c.weight = WT_W'($urandom_range(0, wmax));
    endcase
    c.pop_allowed = ($urandom_range(0, 4) != 0);
    return c;
  endfunction

  task automatic wait_drained();
    while (cmd_backlog.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_capacity(input int value);
    wait_drained();
    repeat (8) @(posedge clk);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value[CAP_W-1:0];
    cap_now = value;
    cap_settings++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(input int cap, input int idle_pct, input int stall_pct,
                           input int n_items, input int push_pct, input int wmax);
    write_capacity(cap);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2)
        wait_drained();
      cmd_backlog.insert(cmd_backlog.size(), rand_cmd(push_pct, wmax));
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_capacity(200);
    enqueue_cmd(OP_POP, 0, 0, 1'b1);
    enqueue_cmd(OP_TRIM, 0, 0, 1'b0);
    enqueue_cmd(OP_PUSH, 16'hFFFF, 0, 1'b0);
    enqueue_cmd(OP_PUSH, 0, 100, 1'b1);
    enqueue_cmd(OP_PUSH, 16'h1234, 100, 1'b0);
    enqueue_cmd(OP_POP, 0, 0, 1'b0);
    enqueue_cmd(OP_PUSH, 16'hABCD, 50, 1'b1);
    enqueue_cmd(OP_POP, 16'hFFFF, 16'hFFFF, 1'b1);
    enqueue_cmd(OP_TRIM, 0, 0, 1'b1);
    enqueue_cmd(OP_UNUSED, 16'hFFFF, 16'hFFFF, 1'b1);
    enqueue_cmd(OP_PUSH, 16'h5555, 16'hFFFF, 1'b1);
    enqueue_cmd(OP_POP, 0, 0, 1'b1);
    enqueue_cmd(OP_PUSH, 16'hAAAA, 200, 1'b0);
    enqueue_cmd(OP_PUSH, 16'h5555, 0, 1'b0);
    enqueue_cmd(OP_PUSH, 16'h0F0F, 1, 1'b0);
    enqueue_cmd(OP_PUSH, 16'hAAAA, 200, 1'b0);
    enqueue_cmd(OP_PUSH, 16'h5555, 0, 1'b0);

    // lower the bound with items held, then trim and push against it
    write_capacity(100);
    enqueue_cmd(OP_PUSH, 16'h3C3C, 0, 1'b0);
    enqueue_cmd(OP_TRIM, 0, 0, 1'b0);
    enqueue_cmd(OP_PUSH, 16'h8001, 100, 1'b0);
    enqueue_cmd(OP_PUSH, 16'h7FFE, 1, 1'b0);
    enqueue_cmd(OP_POP, 0, 0, 1'b1);

    run_phase(CAP_MAX, 0, 0, 250, 75, 4000);
    run_phase(5000, 88, 0, 200, 55, 3000);
    run_phase(0, 0, 88, 150, 50, 3);
    run_phase(200000, 19, 19, 250, 60, 65535);
    run_phase(1024, 0, 0, 180, 60, 700);

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Ran %0d commands under %0d capacity settings; %0d results checked,",
             words_in, cap_settings, words_out);
    $display("%0d items dropped by push or trim, %0d pops delivered, %0d pushes refused",
             items_dropped, pops_delivered, pushes_refused);
    if (err_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout: %0d results still outstanding", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
